// ===== hw/rtl/work_stealing_deque_top_defines.svh =====
// Assertion macros shared by the work-stealing deque RTL.
`ifndef WORK_STEALING_DEQUE_TOP_DEFINES_SVH
`define WORK_STEALING_DEQUE_TOP_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, checked on every rising edge outside reset.
`define WSD_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("work stealing deque: assertion failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define WSD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("work stealing deque: assertion failed");
`else
`define WSD_ASSERT_NOW(label, clk, rstn, ante, cons)
`define WSD_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// ===== hw/rtl/wsd_pkg.sv =====
// Package with request and status codes and field widths of the work-stealing deque.
package wsd_pkg;

    // Default sizing of the item store.
    localparam int unsigned DEF_CAPACITY   = 1024;
    localparam int unsigned DEF_ITEM_WIDTH = 32;

    // Fixed widths of the stream fields.
    localparam int unsigned REQ_W    = 2;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned OCC_W    = 11;

    // Packed stream widths; the tdata widths are rounded up to whole bytes.
    localparam int unsigned S_TDATA_W = 32;
    localparam int unsigned M_TDATA_W = 48;
    localparam int unsigned M_TUSER_W = 3;

    typedef logic [REQ_W-1:0]    req_t;
    typedef logic [STATUS_W-1:0] status_t;

    // Request codes.
    localparam req_t REQ_PUSH  = 2'd0;
    localparam req_t REQ_POP   = 2'd1;
    localparam req_t REQ_STEAL = 2'd2;

    // Status codes.
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

endpackage

// ===== hw/rtl/wsd_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module wsd_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hw/rtl/work_stealing_deque_top.sv =====
// Work-stealing deque: a push, a rejected request or a no-op goes straight into the registered
// result slot; a pop or steal that returns an item passes first through the registered read of
// the item store RAM (state S_READ). Throughput is one request per cycle for pushes; a
// successful pop or steal holds off new requests while its store read is outstanding, and
// output back-pressure holds off new requests until the result slot drains.
// Reset clears the pointers, the count and the output slot; the store itself is not cleared.
`include "work_stealing_deque_top_defines.svh"

module work_stealing_deque_top
    import wsd_pkg::*;
#(
    parameter int unsigned CAPACITY   = DEF_CAPACITY,
    parameter int unsigned ITEM_WIDTH = DEF_ITEM_WIDTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Request channel.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // [31:0] push_value
    input  logic [REQ_W-1:0]     s_axis_tuser,  // [1:0] req_type
    // Result channel.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,  // [31:0] item_out, [42:32] occupancy, rest 0
    output logic [M_TUSER_W-1:0] m_axis_tuser   // [1:0] status, [2] item_valid
);

    localparam int unsigned PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    // Sequencer states.
    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic             state_reg, state_next;
    logic [PTR_W-1:0] top_reg, top_next;
    logic [PTR_W-1:0] bot_reg, bot_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             m_valid_reg, m_valid_next;

    logic [STATUS_W-1:0] status_reg, status_next;
    logic                ivalid_reg, ivalid_next;
    logic [VALUE_W-1:0]  item_reg, item_next;
    logic [OCC_W-1:0]    occ_reg, occ_next;
    logic                out_load;

    logic                  accept;
    logic                  is_empty;
    logic                  is_full;
    logic [PTR_W-1:0]      bot_inc, bot_dec, top_inc;
    logic                  ram_we;
    logic [PTR_W-1:0]      ram_raddr;
    logic [ITEM_WIDTH-1:0] ram_wdata;
    logic [ITEM_WIDTH-1:0] ram_rdata;

    // Item store.
    wsd_ram #(
        .WIDTH (ITEM_WIDTH),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (aclk),
        .wr_en   (ram_we),
        .wr_addr (bot_reg),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Handshake and occupancy flags.
    assign s_axis_tready = (state_reg == S_IDLE) && (!m_valid_reg || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign is_empty      = (count_reg == '0);
    assign is_full       = (count_reg == CNT_W'(CAPACITY));

    // Circular pointer steps.
    assign bot_inc = (bot_reg == PTR_W'(CAPACITY - 1)) ? '0 : bot_reg + 1'b1;
    assign bot_dec = (bot_reg == '0) ? PTR_W'(CAPACITY - 1) : bot_reg - 1'b1;
    assign top_inc = (top_reg == PTR_W'(CAPACITY - 1)) ? '0 : top_reg + 1'b1;

    assign ram_wdata = ITEM_WIDTH'(64'(s_axis_tdata[VALUE_W-1:0]));

    // Request decode, pointer update and result formation.
    always_comb begin
        state_next   = state_reg;
        top_next     = top_reg;
        bot_next     = bot_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        ram_we       = 1'b0;
        ram_raddr    = top_reg;
        out_load     = 1'b0;
        status_next  = ST_OK;
        ivalid_next  = 1'b0;
        item_next    = '0;
        occ_next     = OCC_W'(32'(count_reg));

        if (state_reg == S_READ) begin
            // The store read issued at the transfer has returned.
            out_load    = 1'b1;
            ivalid_next = 1'b1;
            item_next   = VALUE_W'(64'(ram_rdata));
            state_next  = S_IDLE;
        end else if (accept) begin
            case (s_axis_tuser)
                REQ_PUSH: begin
                    out_load = 1'b1;
                    if (is_full) begin
                        status_next = ST_FULL;
                    end else begin
                        ram_we     = 1'b1;
                        bot_next   = bot_inc;
                        count_next = count_reg + 1'b1;
                        occ_next   = OCC_W'(32'(count_next));
                    end
                end
                REQ_POP: begin
                    if (is_empty) begin
                        out_load    = 1'b1;
                        status_next = ST_EMPTY;
                    end else begin
                        ram_raddr  = bot_dec;
                        bot_next   = bot_dec;
                        count_next = count_reg - 1'b1;
                        state_next = S_READ;
                    end
                end
                REQ_STEAL: begin
                    if (is_empty) begin
                        out_load    = 1'b1;
                        status_next = ST_EMPTY;
                    end else begin
                        ram_raddr  = top_reg;
                        top_next   = top_inc;
                        count_next = count_reg - 1'b1;
                        state_next = S_READ;
                    end
                end
                default: begin
                    // Unused code leaves the state alone and reports the count.
                    out_load = 1'b1;
                end
            endcase
        end

        if (out_load) begin
            m_valid_next = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            top_reg     <= '0;
            bot_reg     <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            top_reg     <= top_next;
            bot_reg     <= bot_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload register.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            status_reg <= status_next;
            ivalid_reg <= ivalid_next;
            item_reg   <= item_next;
            occ_reg    <= occ_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(M_TDATA_W - VALUE_W - OCC_W){1'b0}}, occ_reg, item_reg};
    assign m_axis_tuser  = {ivalid_reg, status_reg};

    // The count never goes beyond the store size.
    `WSD_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(CAPACITY))
    // A store read always lands in the result slot in the following cycle.
    `WSD_ASSERT_NEXT(a_read_done, aclk, aresetn, state_reg == S_READ, m_valid_reg && state_reg == S_IDLE)
    // No new request is taken while a store read is outstanding.
    `WSD_ASSERT_NOW(a_read_stall, aclk, aresetn, state_reg == S_READ, !s_axis_tready)
    // A push into a full store leaves the pointers and count untouched.
    `WSD_ASSERT_NEXT(a_full_push, aclk, aresetn, accept && s_axis_tuser == REQ_PUSH && is_full, $stable(count_reg) && $stable(bot_reg))

endmodule

// ===== tb/wsd_checker.sv =====
// Checker that follows both channels of the work-stealing deque and compares every result.
module wsd_checker
    import wsd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // [31:0] push_value
    input  logic [REQ_W-1:0]     s_axis_tuser,   // [1:0] req_type
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [M_TDATA_W-1:0] m_axis_tdata,   // [31:0] item_out, [42:32] occupancy, rest 0
    input  logic [M_TUSER_W-1:0] m_axis_tuser,   // [1:0] status, [2] item_valid
    output int                   mismatch_count,
    output int                   awaited_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SLOT_W = $clog2(DEF_CAPACITY);

    // One result of the deque, as it should appear on the result channel.
    typedef struct packed {
        status_t            status;
        logic               item_valid;
        logic [VALUE_W-1:0] item;
        logic [OCC_W-1:0]   occupancy;
    } deque_result_t;

    // Shadow copy of the deque: circular store, both ends and the item count.
    logic [DEF_ITEM_WIDTH-1:0] slot_mem [DEF_CAPACITY];
    logic [SLOT_W-1:0]         oldest_slot;
    logic [SLOT_W-1:0]         free_slot;
    logic [OCC_W-1:0]          held_items;

    // Results of accepted requests that have not come out yet, oldest first.
    deque_result_t awaited_results [$];

    // Applies one request to the shadow deque and returns the result it must produce.
    function automatic deque_result_t deque_apply(req_t kind, logic [VALUE_W-1:0] value);
        deque_result_t res;
        res = '{status: ST_OK, item_valid: 1'b0, item: '0, occupancy: '0};
        case (kind)
            REQ_PUSH: begin
                if (held_items >= DEF_CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    slot_mem[free_slot] = value[DEF_ITEM_WIDTH-1:0];
                    free_slot = free_slot + 1'b1;
                    held_items = held_items + 1'b1;
                end
            end
            REQ_POP: begin
                if (held_items == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    free_slot = free_slot - 1'b1;
                    res.item = VALUE_W'(slot_mem[free_slot]);
                    res.item_valid = 1'b1;
                    held_items = held_items - 1'b1;
                end
            end
            REQ_STEAL: begin
                if (held_items == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.item = VALUE_W'(slot_mem[oldest_slot]);
                    oldest_slot = oldest_slot + 1'b1;
                    res.item_valid = 1'b1;
                    held_items = held_items - 1'b1;
                end
            end
            default: begin
                // The unused request code leaves the deque as it stands.
            end
        endcase
        res.occupancy = held_items;
        return res;
    endfunction

    // Reports one field that differs from its expected value.
    function automatic void check_field(string field, logic [M_TDATA_W-1:0] want,
                                        logic [M_TDATA_W-1:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        end
    endfunction

    // Predict on every request transfer and compare on every result transfer.
    always @(posedge aclk) begin
        deque_result_t want;
        deque_result_t fresh;
        if (!aresetn) begin
            oldest_slot = '0;
            free_slot = '0;
            held_items = '0;
            mismatch_count = 0;
            awaited_results.delete();
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                fresh = deque_apply(req_t'(s_axis_tuser), s_axis_tdata[VALUE_W-1:0]);
                awaited_results = {awaited_results, fresh};
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (awaited_results.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result with none expected, actual tdata %0h tuser %0h",
                             $time, m_axis_tdata, m_axis_tuser);
                end else begin
                    want = awaited_results.pop_front();
                    check_field("status", want.status, m_axis_tuser[STATUS_W-1:0]);
                    check_field("item_valid", want.item_valid, m_axis_tuser[STATUS_W]);
                    check_field("item_out", want.item, m_axis_tdata[VALUE_W-1:0]);
                    check_field("occupancy", want.occupancy, m_axis_tdata[VALUE_W +: OCC_W]);
                    check_field("tdata padding", '0,
                                m_axis_tdata[M_TDATA_W-1:VALUE_W+OCC_W]);
                end
            end
        end
        awaited_count = awaited_results.size();
    end

endmodule

// ===== tb/tb_work_stealing_deque_top.sv =====
// Top of the work-stealing deque testbench: clock, reset, request and ready stimulus, verdict.
module tb_work_stealing_deque_top;
    timeunit 1ns;
    timeprecision 1ps;

    import wsd_pkg::*;

    // The request code that the deque treats as a no-op.
    localparam req_t REQ_NOOP = 2'd3;

    localparam int unsigned IDLE_PERCENT = 29;
    localparam int unsigned FILL_ITEMS   = 200;
    localparam int unsigned STEADY_FILL  = 150;
    localparam int unsigned DRAIN_ITEMS  = 210;
    localparam int unsigned RANDOM_ITEMS = 420;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;   // [31:0] push_value
    logic [REQ_W-1:0]     s_axis_tuser;   // [1:0] req_type
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;   // [31:0] item_out, [42:32] occupancy, rest 0
    logic [M_TUSER_W-1:0] m_axis_tuser;   // [1:0] status, [2] item_valid

    // While set, neither side idles.
    logic        steady_flow = 1'b0;
    int          mismatch_count;
    int          awaited_count;
    int unsigned cycle_count;

    work_stealing_deque_top DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    wsd_checker checker_inst (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .mismatch_count (mismatch_count),
        .awaited_count  (awaited_count)
    );

    // 4 ns clock.
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // The result side stalls at random unless the flow is steady.
    always @(negedge aclk) begin
        m_axis_tready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // Watchdog: ends the run if it takes far longer than the slowest correct run.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // Offers one request after a random gap and holds it until the transfer.
    // Called and returning at a falling edge.
    task automatic send_request(input req_t kind, input logic [VALUE_W-1:0] value);
        while (!steady_flow && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= $urandom;
            s_axis_tuser <= req_t'($urandom_range(0, 3));
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= value;
        s_axis_tuser <= kind;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Stops offering requests until every expected result has come out.
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        wait (awaited_count == 0);
        @(negedge aclk);
    endtask

    // Item value with the all-zero and all-one extremes mixed in.
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int unsigned roll;
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = REQ_PUSH;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part: empty store, no-ops, extremes, last item by steal and by pop.
        send_request(REQ_POP, 32'h0000_0000);
        send_request(REQ_STEAL, 32'hFFFF_FFFF);
        send_request(REQ_NOOP, 32'h1234_5678);
        send_request(REQ_PUSH, 32'h0000_0000);
        send_request(REQ_PUSH, 32'hFFFF_FFFF);
        send_request(REQ_PUSH, 32'hA5A5_5A5A);
        send_request(REQ_NOOP, 32'hFFFF_FFFF);
        send_request(REQ_POP, 32'h0000_0000);
        send_request(REQ_STEAL, 32'h0000_0000);
        send_request(REQ_STEAL, 32'h0000_0000);
        send_request(REQ_STEAL, 32'h0000_0000);
        send_request(REQ_PUSH, 32'h5555_5555);
        send_request(REQ_POP, 32'hFFFF_FFFF);
        send_request(REQ_POP, 32'h0000_0000);
        send_request(REQ_PUSH, 32'hAAAA_AAAA);
        send_request(REQ_PUSH, 32'h0000_0001);
        send_request(REQ_PUSH, 32'h8000_0000);
        send_request(REQ_STEAL, 32'h0000_0000);
        send_request(REQ_POP, 32'h0000_0000);
        send_request(REQ_POP, 32'h0000_0000);
        send_request(REQ_NOOP, 32'h0000_0000);
        hold_until_drained();

        // Build up a deep store with a run of pushes.
        // The first part runs without idling on either side.
        for (int unsigned i = 0; i < FILL_ITEMS; i++) begin
            steady_flow <= (i < STEADY_FILL);
            send_request(REQ_PUSH, pick_value());
        end

        // Empty it again from both ends, running into the empty store at the end.
        for (int unsigned i = 0; i < DRAIN_ITEMS; i++) begin
            send_request($urandom_range(0, 1) ? REQ_POP : REQ_STEAL, pick_value());
        end

        // Random mix that stays at low occupancy, so the store empties often.
        for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
            steady_flow <= (i >= 200 && i < 300);
            if (i == RANDOM_ITEMS / 2 || $urandom_range(0, 199) == 0) begin
                hold_until_drained();
            end
            roll = $urandom_range(0, 99);
            if (roll < 42) begin
                send_request(REQ_PUSH, pick_value());
            end else if (roll < 68) begin
                send_request(REQ_POP, pick_value());
            end else if (roll < 94) begin
                send_request(REQ_STEAL, pick_value());
            end else begin
                send_request(REQ_NOOP, pick_value());
            end
        end

        // Let the last results come out, then give the verdict.
        s_axis_tvalid <= 1'b0;
        wait (awaited_count == 0);
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && awaited_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/wsd_pkg.sv
hw/rtl/wsd_ram.sv
hw/rtl/work_stealing_deque_top.sv
tb/wsd_checker.sv
tb/tb_work_stealing_deque_top.sv
